/* design/civfe_pkg.sv */
package civfe_pkg;

   localparam int CIVFE_FREQ_W      = 34;
   localparam int CIVFE_BIN_W       = 30;
   localparam int CIVFE_DIGITS      = 9;
   localparam int CIVFE_BCD_W       = 4 * CIVFE_DIGITS;
   localparam int CIVFE_DD_STEPS    = CIVFE_BIN_W / 2;
   localparam int CIVFE_STEP_W      = $clog2(CIVFE_DD_STEPS);
   localparam int CIVFE_IDX_W       = 5;
   localparam int CIVFE_QUEUE_DEPTH = 2;

   localparam logic [CIVFE_FREQ_W-1:0] CIVFE_FREQ_LIMIT = 34'd1000000000;
   localparam logic [CIVFE_BIN_W-1:0]  CIVFE_FREQ_SAT   = 30'd999999999;

   localparam logic [CIVFE_IDX_W-1:0] CIVFE_BAND_END = 5'd6;
   localparam logic [CIVFE_IDX_W-1:0] CIVFE_LAST_IDX = 5'd17;

   localparam logic [7:0] CIVFE_ADDR_RESET = 8'h52;
   localparam logic [7:0] CIVFE_PREAMBLE   = 8'hFE;
   localparam logic [7:0] CIVFE_CTRL_ADDR  = 8'hE0;
   localparam logic [7:0] CIVFE_CMD_BAND   = 8'h07;
   localparam logic [7:0] CIVFE_CMD_FREQ   = 8'h05;
   localparam logic [7:0] CIVFE_BAND_MAIN  = 8'hD0;
   localparam logic [7:0] CIVFE_BAND_SUB   = 8'hD1;
   localparam logic [7:0] CIVFE_EOM        = 8'hFD;

   typedef struct packed {
      logic [CIVFE_BCD_W-1:0] bcd;
      logic                   band;
      logic                   clamped;
   } civfe_entry_type;

   // One double-dabble step: correct every digit of five or more, then shift in one bit.
   function automatic logic [CIVFE_BCD_W-1:0] civfe_dd_step(
      input logic [CIVFE_BCD_W-1:0] bcd,
      input logic                   bit_in
   );
      logic [CIVFE_BCD_W-1:0] adj;
      adj = bcd;
      for (int i = 0; i < CIVFE_DIGITS; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end
      end
      return {adj[CIVFE_BCD_W-2:0], bit_in};
   endfunction

endpackage

/* design/civfe_channels.sv */
interface civfe_req_if;
   logic                             valid;
   logic                             ready;
   logic [civfe_pkg::CIVFE_FREQ_W-1:0] freq_10hz;
   logic                             band;

   modport source (output valid, output freq_10hz, output band, input ready);
   modport sink   (input valid, input freq_10hz, input band, output ready);
endinterface

interface civfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       frame_end;
   logic       last;
   logic       clamped;

   modport source (output valid, output tx_byte, output frame_end, output last,
                   output clamped, input ready);
   modport sink   (input valid, input tx_byte, input frame_end, input last,
                   input clamped, output ready);
endinterface

interface civfe_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] civ_address;

   modport source (output valid, output civ_address, input ready);
   modport sink   (input valid, input civ_address, output ready);
endinterface

/* design/civfe_front.sv */
module civfe_front (
   input  logic                        clock,
   input  logic                        reset,
   civfe_req_if.sink                   req,
   output civfe_pkg::civfe_entry_type  push_entry,
   output logic                        push,
   input  logic                        push_ready
);
   import civfe_pkg::*;

   typedef enum logic [2:0] {
      FE_IDLE = 3'b001,
      FE_CONV = 3'b010,
      FE_PUSH = 3'b100
   } civfe_front_state_type;

   civfe_front_state_type     state_ff, state_in;
   logic [CIVFE_STEP_W-1:0]   step_ff, step_in;
   logic [CIVFE_BIN_W-1:0]    bin_ff, bin_in;
   logic [CIVFE_BCD_W-1:0]    bcd_ff, bcd_in;
   logic                      band_ff, band_in;
   logic                      clamped_ff, clamped_in;
   logic                      accept;
   logic                      over;

   assign req.ready = (state_ff == FE_IDLE) || ((state_ff == FE_PUSH) && push_ready);
   assign accept    = req.valid && req.ready;
   assign over      = (req.freq_10hz >= CIVFE_FREQ_LIMIT);
   assign push      = (state_ff == FE_PUSH) && push_ready;

   assign push_entry.bcd     = bcd_ff;
   assign push_entry.band    = band_ff;
   assign push_entry.clamped = clamped_ff;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      band_in    = band_ff;
      clamped_in = clamped_ff;
      unique case (state_ff)
         FE_IDLE, FE_PUSH: begin
            if (push) begin
               state_in = FE_IDLE;
            end
            if (accept) begin
               state_in   = FE_CONV;
               step_in    = '0;
               bin_in     = over ? CIVFE_FREQ_SAT : req.freq_10hz[CIVFE_BIN_W-1:0];
               bcd_in     = '0;
               band_in    = req.band;
               clamped_in = over;
            end
         end
         FE_CONV: begin
            // Two binary bits are folded into the BCD word each cycle.
            bcd_in  = civfe_dd_step(civfe_dd_step(bcd_ff, bin_ff[CIVFE_BIN_W-1]),
                                    bin_ff[CIVFE_BIN_W-2]);
            bin_in  = {bin_ff[CIVFE_BIN_W-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == CIVFE_STEP_W'(CIVFE_DD_STEPS - 1)) begin
               state_in = FE_PUSH;
            end
         end
         default: state_in = FE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff    <= step_in;
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      band_ff    <= band_in;
      clamped_ff <= clamped_in;
   end

endmodule

/* design/civfe_queue.sv */
module civfe_queue #(
   parameter int DEPTH = civfe_pkg::CIVFE_QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  civfe_pkg::civfe_entry_type  wr_entry,
   input  logic                        wr_en,
   output logic                        wr_ready,
   output civfe_pkg::civfe_entry_type  rd_entry,
   output logic                        rd_valid,
   input  logic                        rd_en
);
   import civfe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   civfe_entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_wr;
   logic              do_rd;

   assign wr_ready = (count_ff != CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign do_wr    = wr_en && wr_ready;
   assign do_rd    = rd_en && rd_valid;
   assign rd_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

/* design/civfe_back.sv */
module civfe_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [7:0]                  civ_address,
   input  civfe_pkg::civfe_entry_type  q_entry,
   input  logic                        q_valid,
   output logic                        q_pop,
   civfe_rsp_if.source                 rsp
);
   import civfe_pkg::*;

   civfe_entry_type          cur_ff, cur_in;
   logic                     busy_ff, busy_in;
   logic [CIVFE_IDX_W-1:0]   idx_ff, idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               tx_byte_ff, tx_byte_in;
   logic                     frame_end_ff, frame_end_in;
   logic                     last_ff, last_in;
   logic                     clamped_ff, clamped_in;
   logic                     load;
   logic                     emit;
   logic                     at_last;
   logic [7:0]               sel_byte;

   assign load    = !rsp_valid_ff || rsp.ready;
   assign emit    = busy_ff && load;
   assign at_last = (idx_ff == CIVFE_LAST_IDX);
   // The next item is popped while idle or in the cycle the closing byte is loaded for output.
   assign q_pop   = q_valid && (!busy_ff || (emit && at_last));

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.tx_byte   = tx_byte_ff;
   assign rsp.frame_end = frame_end_ff;
   assign rsp.last      = last_ff;
   assign rsp.clamped   = clamped_ff;

   always_comb begin
      unique case (idx_ff)
         5'd0, 5'd1, 5'd7, 5'd8: sel_byte = CIVFE_PREAMBLE;
         5'd2, 5'd9:             sel_byte = civ_address;
         5'd3, 5'd10:            sel_byte = CIVFE_CTRL_ADDR;
         5'd4:                   sel_byte = CIVFE_CMD_BAND;
         5'd5:                   sel_byte = cur_ff.band ? CIVFE_BAND_SUB : CIVFE_BAND_MAIN;
         5'd11:                  sel_byte = CIVFE_CMD_FREQ;
         5'd12:                  sel_byte = {cur_ff.bcd[3:0], 4'h0};
         5'd13:                  sel_byte = cur_ff.bcd[11:4];
         5'd14:                  sel_byte = cur_ff.bcd[19:12];
         5'd15:                  sel_byte = cur_ff.bcd[27:20];
         5'd16:                  sel_byte = cur_ff.bcd[35:28];
         default:                sel_byte = CIVFE_EOM;
      endcase
   end

   always_comb begin
      cur_in       = q_pop ? q_entry : cur_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      tx_byte_in   = tx_byte_ff;
      frame_end_in = frame_end_ff;
      last_in      = last_ff;
      clamped_in   = clamped_ff;
      if (load) begin
         rsp_valid_in = busy_ff;
      end
      if (emit) begin
         tx_byte_in   = sel_byte;
         frame_end_in = (idx_ff == CIVFE_BAND_END) || at_last;
         last_in      = at_last;
         clamped_in   = cur_ff.clamped;
         idx_in       = at_last ? '0 : idx_ff + 1'b1;
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      tx_byte_ff   <= tx_byte_in;
      frame_end_ff <= frame_end_in;
      last_ff      <= last_in;
      clamped_ff   <= clamped_in;
   end

   a_last_closes_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> frame_end_ff)
      else $error("last byte is not a frame terminator");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= CIVFE_LAST_IDX)
      else $error("byte index beyond the end of the run");

   a_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> idx_ff == '0)
      else $error("byte index not at the start while idle");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      emit && at_last && !q_valid |=> !busy_ff)
      else $error("sequencer still busy after the closing byte");

endmodule

/* design/civ_frequency_frame_encoder_core.sv */
// Channel   Direction  Payload                                  Transfer when
// req       in         freq_10hz[33:0], band                    valid && ready
// rsp       out        tx_byte[7:0], frame_end, last, clamped   valid && ready
// csr       in         civ_address[7:0]                         valid (ready tied high)
//
// Each request yields eighteen byte transfers; the byte sequencer sends one per cycle while rsp
// is not stalled.
// The BCD conversion and its hand-over to the queue overlap with the previous run.
// Synchronous reset empties the queue and sets the bus address to 0x52.
// A stall on rsp holds the output register; the queue lets conversion run ahead meanwhile.
module civ_frequency_frame_encoder_core #(
   parameter int QUEUE_DEPTH = civfe_pkg::CIVFE_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   civfe_req_if.sink     req,
   civfe_rsp_if.source   rsp,
   civfe_csr_if.sink     csr
);
   import civfe_pkg::*;

   civfe_entry_type  push_entry;
   civfe_entry_type  q_entry;
   logic             push;
   logic             push_ready;
   logic             q_valid;
   logic             q_pop;
   logic [7:0]       civ_address_ff, civ_address_in;

   assign csr.ready      = 1'b1;
   assign civ_address_in = (csr.valid && csr.ready) ? csr.civ_address : civ_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         civ_address_ff <= CIVFE_ADDR_RESET;
      end else begin
         civ_address_ff <= civ_address_in;
      end
   end

   civfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_entry (push_entry),
      .push       (push),
      .push_ready (push_ready)
   );

   civfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_entry (push_entry),
      .wr_en    (push),
      .wr_ready (push_ready),
      .rd_entry (q_entry),
      .rd_valid (q_valid),
      .rd_en    (q_pop)
   );

   civfe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .civ_address (civ_address_ff),
      .q_entry     (q_entry),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .rsp         (rsp)
   );

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

   localparam int FREQ_W          = civfe_pkg::CIVFE_FREQ_W;
   localparam int RUN_BYTES       = 18;
   localparam int BAND_FRAME_END  = 6;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 70;
   localparam int DRAIN_CYCLES    = 40;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_CYCLES = 1500000;
   localparam int REPORT_LIMIT    = 40;

   localparam logic [7:0] ADDR_AT_RESET = 8'h52;
   localparam logic [7:0] PREAMBLE_BYTE = 8'hfe;
   localparam logic [7:0] CONTROLLER    = 8'he0;
   localparam logic [7:0] CMD_SET_BAND  = 8'h07;
   localparam logic [7:0] CMD_SET_FREQ  = 8'h05;
   localparam logic [7:0] BAND_MAIN     = 8'hd0;
   localparam logic [7:0] BAND_SUB      = 8'hd1;
   localparam logic [7:0] END_OF_FRAME  = 8'hfd;

   localparam longint unsigned TEN_GHZ    = 64'd1000000000;
   localparam longint unsigned ALL_NINES  = 64'd999999999;

   // Upper bit is the band select, the rest the frequency in 10 Hz units.
   localparam logic [FREQ_W:0] DIRECTED [20] = '{
      {1'b0, 34'd0},          {1'b1, 34'd0},          {1'b0, 34'd1},
      {1'b1, 34'd9},          {1'b0, 34'd10},         {1'b1, 34'd14521000},
      {1'b0, 34'd43512345},   {1'b1, 34'd123456789},  {1'b0, 34'd987654321},
      {1'b1, 34'd999999999},  {1'b0, 34'd1000000000}, {1'b1, 34'd1000000001},
      {1'b0, 34'd9999999999}, {1'b1, 34'h3ffffffff},  {1'b0, 34'h040000000},
      {1'b1, 34'h2aaaaaaaa},  {1'b0, 34'h155555555},  {1'b1, 34'd99999999},
      {1'b0, 34'd100000000},  {1'b1, 34'd500000000}
   };

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_end;
      logic       last;
      logic       clamped;
   } frame_byte_type;

   class civ_frame_tracker_type;
      logic [7:0]     address;
      frame_byte_type pending_bytes [$];
      int             mismatches;
      int             bytes_checked;
      int             saturated;

      function new();
         address       = ADDR_AT_RESET;
         mismatches    = 0;
         bytes_checked = 0;
         saturated     = 0;
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("tb: %s", msg);
         end
      endtask

      // Builds the band select frame and the set-frequency frame for one request.
      function void note_request(logic [FREQ_W-1:0] freq, logic band_sel);
         longint unsigned value;
         logic            sat;
         logic [3:0]      digit [9];
         logic [7:0]      seq [RUN_BYTES];
         value = freq;
         sat   = 1'b0;
         if (value >= TEN_GHZ) begin
            value = ALL_NINES;
            sat   = 1'b1;
            saturated++;
         end
         for (int k = 0; k < 9; k++) begin
            digit[k] = 4'(value % 10);
            value    = value / 10;
         end
         seq[0]  = PREAMBLE_BYTE;
         seq[1]  = PREAMBLE_BYTE;
         seq[2]  = address;
         seq[3]  = CONTROLLER;
         seq[4]  = CMD_SET_BAND;
         seq[5]  = band_sel ? BAND_SUB : BAND_MAIN;
         seq[6]  = END_OF_FRAME;
         seq[7]  = PREAMBLE_BYTE;
         seq[8]  = PREAMBLE_BYTE;
         seq[9]  = address;
         seq[10] = CONTROLLER;
         seq[11] = CMD_SET_FREQ;
         seq[12] = {digit[0], 4'h0};
         seq[13] = {digit[2], digit[1]};
         seq[14] = {digit[4], digit[3]};
         seq[15] = {digit[6], digit[5]};
         seq[16] = {digit[8], digit[7]};
         seq[17] = END_OF_FRAME;
         for (int k = 0; k < RUN_BYTES; k++) begin
            pending_bytes.push_back({seq[k], k == BAND_FRAME_END || k == RUN_BYTES - 1,
                                     k == RUN_BYTES - 1, sat});
         end
      endfunction

      task check_byte(logic [7:0] tx, logic fend, logic fin, logic clamp);
         frame_byte_type want;
         int             pos;
         pos = bytes_checked % RUN_BYTES;
         bytes_checked++;
         if (pending_bytes.size() == 0) begin
            report($sformatf("byte %02h transferred with nothing expected", tx));
            return;
         end
         want = pending_bytes.pop_front();
         if (tx !== want.tx_byte) begin
            report($sformatf("byte %0d of run: tx_byte %02h, expected %02h",
                             pos, tx, want.tx_byte));
         end
         if (fend !== want.frame_end) begin
            report($sformatf("byte %0d of run: frame_end %b, expected %b",
                             pos, fend, want.frame_end));
         end
         if (fin !== want.last) begin
            report($sformatf("byte %0d of run: last %b, expected %b", pos, fin, want.last));
         end
         if (clamp !== want.clamped) begin
            report($sformatf("byte %0d of run: clamped %b, expected %b",
                             pos, clamp, want.clamped));
         end
      endtask

      task check_drained();
         if (pending_bytes.size() != 0) begin
            report($sformatf("%0d expected bytes never transferred", pending_bytes.size()));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   civfe_req_if req_ch ();
   civfe_rsp_if rsp_ch ();
   civfe_csr_if csr_ch ();

   civ_frequency_frame_encoder_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   civ_frame_tracker_type book;
   int requests_sent    = 0;
   int address_settings = 0;
   int hold_off_left    = 0;
   int cycle_count      = 0;
   bit calm             = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= WATCHDOG_CYCLES);
      $display("tb: FAIL");
      $finish;
   end

   // Mostly short gaps, now and then a long one; none at all in a calm phase.
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [FREQ_W-1:0] random_freq();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return FREQ_W'($urandom_range(0, 999999999));
      if (r < 70) return FREQ_W'($urandom_range(0, 9999));
      if (r < 82) return FREQ_W'($urandom_range(999999980, 1000000020));
      return {2'($urandom_range(0, 3)), 32'($urandom)};
   endfunction

   // Result side: random stalls, plus the long hold-off counted down here.
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off_left--;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            book.check_byte(rsp_ch.tx_byte, rsp_ch.frame_end, rsp_ch.last, rsp_ch.clamped);
         end
      end
   end

   // Leaves valid high after the transfer so that a following item can go back to back.
   task automatic send_request(input logic [FREQ_W-1:0] freq, input logic band_sel);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.freq_10hz <= freq;
      req_ch.band      <= band_sel;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      book.note_request(freq, band_sel);
      requests_sent++;
   endtask

   task automatic stop_requests();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (book.pending_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic write_address(input logic [7:0] addr);
      @(negedge clock);
      csr_ch.valid       <= 1'b1;
      csr_ch.civ_address <= addr;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      book.address = addr;
      address_settings++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      logic [7:0] addr;
      book               = new();
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.freq_10hz   = '0;
      req_ch.band        = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.civ_address = 8'h00;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The directed items run with the address left at its reset value.
      for (int i = 0; i < $size(DIRECTED); i++) begin
         send_request(DIRECTED[i][FREQ_W-1:0], DIRECTED[i][FREQ_W]);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         stop_requests();
         wait_drained();
         repeat (DRAIN_CYCLES) @(posedge clock);
         calm = (phase == 1);
         case (phase)
            0: begin
               addr = 8'h00;
            end
            1: begin
               addr = 8'hff;
            end
            default: begin
               addr = 8'($urandom);
            end
         endcase
         write_address(addr);
         for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
            send_request(random_freq(), 1'($urandom_range(0, 1)));
            // The result side stops for a long while; the input must back up behind it.
            if (phase == 3 && item == 10) hold_off_left = HOLD_OFF_CYCLES;
            if (phase == 4 && item == 35) begin
               stop_requests();
               wait_drained();
            end
         end
      end

      stop_requests();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      book.check_drained();

      $display("tb: %0d requests (%0d saturated) gave %0d byte transfers to compare",
               requests_sent, book.saturated, book.bytes_checked);
      $display("tb: %0d bus address settings, one long result hold-off, one drained pause",
               address_settings);
      if (book.mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
